### sv/ksrs_pkg.sv
// Package for the k-mer set read screen: sizes, codes, word types and the
// command and status structs shared by controller, datapath and top level.
// Depends on nothing.
package ksrs_pkg;

    // Bucket count must be a power of two: the bucket is the low code bits.
    localparam int TABLE_BUCKETS = 4096;
    localparam int BUCKET_WAYS   = 4;
    localparam int BUCKET_BITS   = $clog2(TABLE_BUCKETS);

    localparam int CODE_W = 64;
    localparam int KLEN_W = 6;
    localparam int CNT_W  = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd21;
    localparam logic [KLEN_W-1:0] KLEN_MAX   = 6'd32;

    // Register index, taken from paddr[2].
    localparam logic REG_K_SIZE = 1'b0;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SCAN   = 1'b1;

    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [7:0] CHAR_UP_A = 8'h41;
    localparam logic [7:0] CHAR_UP_C = 8'h43;
    localparam logic [7:0] CHAR_UP_G = 8'h47;
    localparam logic [7:0] CHAR_UP_T = 8'h54;
    localparam logic [7:0] CHAR_LO_A = 8'h61;
    localparam logic [7:0] CHAR_LO_C = 8'h63;
    localparam logic [7:0] CHAR_LO_G = 8'h67;
    localparam logic [7:0] CHAR_LO_T = 8'h74;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef struct packed {
        logic              req_type;
        logic [CODE_W-1:0] kmer_code;
        logic [7:0]        base_char;
        logic              end_of_read;
        logic              end_of_pair;
    } req_t;

    typedef struct packed {
        logic             result_kind;
        logic             pair_matched;
        logic             table_full;
        logic [CNT_W-1:0] total_pairs;
        logic [CNT_W-1:0] total_matched;
    } rsp_t;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } slot_t;

    typedef slot_t [BUCKET_WAYS-1:0] row_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic take_ins;
        logic take_scan;
        logic rd_second;
        logic ins_chk_first;
        logic ins_chk_second;
        logic scan_chk;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_blocked;
        logic scan_eop;
    } sts_t;

endpackage

### sv/ksrs_ctrl.sv
// Controller of the k-mer set read screen: sequences the clearing pass,
// the scan (accept, check) and the insert (accept, first check, second read, second check). Depends on ksrs_pkg.
module ksrs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_type,
    output logic            req_ready,
    input  ksrs_pkg::sts_t  sts,
    output ksrs_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_CHK,
        ST_INS_CHK1,
        ST_INS_RD2,
        ST_INS_CHK2
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_type == ksrs_pkg::REQ_INSERT)
                    begin
                        cmd.take_ins = 1'b1;
                        state_next   = ST_INS_CHK1;
                    end
                    else
                    begin
                        cmd.take_scan = 1'b1;
                        state_next    = ST_SCAN_CHK;
                    end
                end
            end
            ST_SCAN_CHK:
            begin
                // A base that ends a pair waits here until the output word is free.
                if (!(sts.scan_eop && sts.out_blocked))
                begin
                    cmd.scan_chk = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_INS_CHK1:
            begin
                cmd.ins_chk_first = 1'b1;
                state_next        = ST_INS_RD2;
            end
            ST_INS_RD2:
            begin
                cmd.rd_second = 1'b1;
                state_next    = ST_INS_CHK2;
            end
            ST_INS_CHK2:
            begin
                if (!sts.out_blocked)
                begin
                    cmd.ins_chk_second = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/ksrs_dp.sv
// Datapath of the k-mer set read screen: rolling window, bucket memory with
// way compare, insert write-back, pair counters and the output word register.
// Depends on ksrs_pkg.
module ksrs_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ksrs_pkg::req_t                 req,
    input  logic [ksrs_pkg::KLEN_W-1:0]    k_size,
    input  ksrs_pkg::cmd_t                 cmd,
    output ksrs_pkg::sts_t                 sts,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output ksrs_pkg::rsp_t                 rsp
);

    localparam int BB   = ksrs_pkg::BUCKET_BITS;
    localparam int CW   = ksrs_pkg::CODE_W;
    localparam int KW   = ksrs_pkg::KLEN_W;
    localparam int NW   = ksrs_pkg::BUCKET_WAYS;
    localparam int PAIRS = ksrs_pkg::CODE_W / 2;

    function automatic logic [1:0] base_bits(input logic [7:0] c);
        logic [1:0] b;
        unique case (c)
            ksrs_pkg::CHAR_UP_A, ksrs_pkg::CHAR_LO_A: b = ksrs_pkg::BASE_A;
            ksrs_pkg::CHAR_UP_C, ksrs_pkg::CHAR_LO_C: b = ksrs_pkg::BASE_C;
            ksrs_pkg::CHAR_UP_G, ksrs_pkg::CHAR_LO_G: b = ksrs_pkg::BASE_G;
            ksrs_pkg::CHAR_UP_T, ksrs_pkg::CHAR_LO_T: b = ksrs_pkg::BASE_T;
            default:                                 b = ksrs_pkg::BASE_A;
        endcase
        return b;
    endfunction

    // Reverse complement of a k-base code: reverse the base order over the
    // whole word, complement, then drop the pairs that came from above 2k.
    function automatic logic [CW-1:0] rev_comp(input logic [CW-1:0] code,
                                               input logic [KW-1:0] k);
        logic [CW-1:0] pr;
        logic [KW:0]   sh;
        for (int i = 0; i < PAIRS; i++)
        begin
            pr[2*(PAIRS-1-i) +: 2] = ~code[2*i +: 2];
        end
        sh = (KW+1)'(CW) - {k, 1'b0};
        return pr >> sh;
    endfunction

    logic [KW-1:0]   k_eff;
    logic [CW-1:0]   win_mask;
    logic [CW-1:0]   win_new;
    logic [KW-1:0]   bases_inc;
    logic [CW-1:0]   ins_code;

    logic [CW-1:0]   window_reg;
    logic [KW-1:0]   bases_reg;
    logic            pair_hit_reg;
    logic [ksrs_pkg::CNT_W-1:0] pair_cnt_reg;
    logic [ksrs_pkg::CNT_W-1:0] match_cnt_reg;
    logic [BB-1:0]   clr_addr_reg;
    logic            rsp_valid_reg;
    ksrs_pkg::rsp_t  rsp_reg;

    logic [CW-1:0]   cmp_code_reg;
    logic            lookup_en_reg;
    logic            eop_reg;
    logic            full_reg;
    ksrs_pkg::row_t  rd_row_reg;

    ksrs_pkg::row_t  tbl_mem [ksrs_pkg::TABLE_BUCKETS];

    logic            row_has;
    logic            row_free;
    logic [NW-1:0]   free_oh;
    ksrs_pkg::row_t  ins_row;
    logic            ins_chk;
    logic            ins_wr;
    logic            drop_now;

    logic            mem_we;
    logic [BB-1:0]   wr_idx;
    ksrs_pkg::row_t  wr_row;
    logic            mem_re;
    logic [BB-1:0]   rd_idx;

    logic            scan_hit;
    logic            verdict;
    logic [ksrs_pkg::CNT_W-1:0] pair_cnt_inc;
    logic [ksrs_pkg::CNT_W-1:0] match_cnt_inc;
    logic            rsp_load;

    always_comb
    begin
        if (k_size == '0)
        begin
            k_eff = KW'(1);
        end
        else if (k_size > ksrs_pkg::KLEN_MAX)
        begin
            k_eff = ksrs_pkg::KLEN_MAX;
        end
        else
        begin
            k_eff = k_size;
        end
        for (int i = 0; i < PAIRS; i++)
        begin
            win_mask[2*i +: 2] = (KW'(i) < k_eff) ? 2'b11 : 2'b00;
        end
    end

    assign win_new   = {window_reg[CW-3:0], base_bits(req.base_char)} & win_mask;
    assign bases_inc = (bases_reg < k_eff) ? bases_reg + KW'(1) : bases_reg;
    assign ins_code  = req.kmer_code & win_mask;

    // Way compare on the row read for the code under test.
    always_comb
    begin
        logic found;
        found   = 1'b0;
        row_has = 1'b0;
        for (int w = 0; w < NW; w++)
        begin
            if (rd_row_reg[w].valid && rd_row_reg[w].code == cmp_code_reg)
            begin
                row_has = 1'b1;
            end
            free_oh[w] = !rd_row_reg[w].valid && !found;
            found      = found || !rd_row_reg[w].valid;
            ins_row[w] = free_oh[w] ? ksrs_pkg::slot_t'{valid: 1'b1, code: cmp_code_reg}
                                    : rd_row_reg[w];
        end
        row_free = found;
    end

    assign ins_chk  = cmd.ins_chk_first || cmd.ins_chk_second;
    assign ins_wr   = ins_chk && !row_has && row_free;
    assign drop_now = !row_has && !row_free;

    assign mem_we = cmd.clr_step || ins_wr;
    assign wr_idx = cmd.clr_step ? clr_addr_reg : cmp_code_reg[BB-1:0];
    assign wr_row = cmd.clr_step ? '0 : ins_row;

    assign mem_re = cmd.take_scan || cmd.take_ins || cmd.rd_second;
    always_comb
    begin
        priority if (cmd.take_scan)
        begin
            rd_idx = win_new[BB-1:0];
        end
        else if (cmd.take_ins)
        begin
            rd_idx = ins_code[BB-1:0];
        end
        else
        begin
            rd_idx = cmp_code_reg[BB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tbl_mem[wr_idx] <= wr_row;
        end
        if (mem_re)
        begin
            rd_row_reg <= tbl_mem[rd_idx];
        end
    end

    assign scan_hit      = lookup_en_reg && row_has;
    assign verdict       = pair_hit_reg || scan_hit;
    assign pair_cnt_inc  = (pair_cnt_reg == '1) ? pair_cnt_reg
                                                : pair_cnt_reg + ksrs_pkg::CNT_W'(1);
    assign match_cnt_inc = (match_cnt_reg == '1) ? match_cnt_reg
                                                 : match_cnt_reg + ksrs_pkg::CNT_W'(1);
    assign rsp_load      = cmd.ins_chk_second || (cmd.scan_chk && eop_reg);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            bases_reg     <= '0;
            pair_hit_reg  <= 1'b0;
            pair_cnt_reg  <= '0;
            match_cnt_reg <= '0;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + BB'(1);
            end
            if (cmd.take_scan)
            begin
                if (req.end_of_read || req.end_of_pair)
                begin
                    window_reg <= '0;
                    bases_reg  <= '0;
                end
                else
                begin
                    window_reg <= win_new;
                    bases_reg  <= bases_inc;
                end
            end
            if (cmd.scan_chk)
            begin
                if (eop_reg)
                begin
                    pair_hit_reg <= 1'b0;
                    pair_cnt_reg <= pair_cnt_inc;
                    if (verdict)
                    begin
                        match_cnt_reg <= match_cnt_inc;
                    end
                end
                else
                begin
                    pair_hit_reg <= verdict;
                end
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take_scan)
        begin
            cmp_code_reg  <= win_new;
            lookup_en_reg <= (bases_inc >= k_eff);
            eop_reg       <= req.end_of_pair;
        end
        else if (cmd.take_ins)
        begin
            cmp_code_reg <= ins_code;
        end
        else if (cmd.ins_chk_first)
        begin
            cmp_code_reg <= rev_comp(cmp_code_reg, k_eff);
            full_reg     <= drop_now;
        end
        if (cmd.ins_chk_second)
        begin
            rsp_reg.result_kind   <= ksrs_pkg::KIND_ACK;
            rsp_reg.pair_matched  <= 1'b0;
            rsp_reg.table_full    <= full_reg || drop_now;
            rsp_reg.total_pairs   <= pair_cnt_reg;
            rsp_reg.total_matched <= match_cnt_reg;
        end
        else if (cmd.scan_chk && eop_reg)
        begin
            rsp_reg.result_kind   <= ksrs_pkg::KIND_VERDICT;
            rsp_reg.pair_matched  <= verdict;
            rsp_reg.table_full    <= 1'b0;
            rsp_reg.total_pairs   <= pair_cnt_inc;
            rsp_reg.total_matched <= verdict ? match_cnt_inc : match_cnt_reg;
        end
    end

    assign sts.clr_last    = (clr_addr_reg == BB'(ksrs_pkg::TABLE_BUCKETS - 1));
    assign sts.out_blocked = rsp_valid_reg && !rsp_ready;
    assign sts.scan_eop    = eop_reg;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The bucket memory has one port of each kind, and a write must land
    // before the following read of the same bucket.
    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("bucket memory read and write in the same cycle");

    a_matched_le_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        match_cnt_reg <= pair_cnt_reg)
        else $error("matched pair count exceeds pair count");

    a_no_load_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |-> !(rsp_valid_reg && !rsp_ready))
        else $error("output word overwritten before it was taken");

    a_clear_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_scan || cmd.take_ins) |-> !cmd.clr_step)
        else $error("item taken during the clearing pass");

endmodule

### sv/kmer_set_read_screen.sv
// Scan word: accepted and its bucket read, then the read row compared; a new word waits until then.
// Insert word: accepted and bucket read, code compare and write-back, reverse-complement read, compare.
// A verdict is registered from the scan compare and an acknowledge from the second insert compare; the
// last step of an insert, or of a base that ends a pair, stalls while the output word still waits to be taken.
// Reset: k of 21, counters zero, then a clearing pass over all 4096 buckets with
// req_ready low; configuration writes are taken during it.
module kmer_set_read_screen (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  ksrs_pkg::req_t                   req_data,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output ksrs_pkg::rsp_t                   rsp_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ksrs_pkg::ADDR_W-1:0]      paddr,
    input  logic [ksrs_pkg::DATA_W-1:0]      pwdata,
    output logic [ksrs_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);

    logic [ksrs_pkg::KLEN_W-1:0] k_size_reg;
    logic                        reg_idx;
    logic                        cfg_wr;
    ksrs_pkg::cmd_t              cmd;
    ksrs_pkg::sts_t              sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == ksrs_pkg::REG_K_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_size_reg <= ksrs_pkg::KLEN_RESET;
        end
        else if (cfg_wr)
        begin
            k_size_reg <= pwdata[ksrs_pkg::KLEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == ksrs_pkg::REG_K_SIZE)
        begin
            prdata[ksrs_pkg::KLEN_W-1:0] = k_size_reg;
        end
    end

    ksrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_data.req_type),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ksrs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_data),
        .k_size    (k_size_reg),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_data)
    );

endmodule
